// ===== hw/rtl/bpsa_pkg.sv =====
// types and constants for the buffer pool slot allocator
package bpsa_pkg;

   localparam int unsigned REQ_TDATA_W = 8;
   localparam int unsigned RSP_TDATA_W = 144;
   localparam int unsigned CSR_DATA_W  = 7;
   localparam int unsigned PCT_W       = 7;
   localparam int unsigned SLOT_IDX_W  = 8;
   localparam int unsigned USED_OUT_W  = 9;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned TOTAL_W     = 33;

   localparam logic [PCT_W-1:0] WARN_THRESHOLD_RESET = 7'd80;

   typedef enum logic {
      OP_GET    = 1'b0,
      OP_RETURN = 1'b1
   } op_type;

   typedef struct packed {
      logic                  high_use;
      logic [TOTAL_W-1:0]    request_total;
      logic [COUNT_W-1:0]    miss_total;
      logic [COUNT_W-1:0]    hit_total;
      logic [PCT_W-1:0]      peak_percent;
      logic [PCT_W-1:0]      utilization_now;
      logic [USED_OUT_W-1:0] used_now;
      logic [PCT_W-1:0]      op_utilization;
      logic [SLOT_IDX_W-1:0] granted_index;
      logic                  granted;
   } rsp_type;

   localparam int unsigned RSP_PAD_W = RSP_TDATA_W - $bits(rsp_type);

endpackage

// ===== hw/rtl/buffer_pool_slot_allocator_top.sv =====
// buffer pool slot allocator: free map, lowest free grant, usage statistics
//
// req channel: one item per request, req_tuser is the kind (0 get, 1 return),
// req_tdata the slot being returned (ignored for get).
// rsp channel: exactly one item per request, carrying the grant, the usage
// figures, the hit and miss counters and the high-use flag.
// csr channel: one write sets the 7-bit warning threshold; csr_ready is
// always high. Write it only while no request is in flight.
// Each request passes through an input register, then the free map lookup,
// priority encode and counter update feeding the result register.
// Throughput is one item per cycle while rsp_tready stays high, set by the
// single read-modify-write of the free map and the usage count.
// Reset (synchronous) marks every slot free, clears the counters and the
// peak, and loads a threshold of 80 percent.
// When the receiver stalls, the result register holds its item and the
// input register still takes one more; req_tready falls only when both
// are full.
module buffer_pool_slot_allocator_top
   import bpsa_pkg::*;
#(
   parameter int unsigned POOL_SLOTS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // slot_index
   input  logic                   req_tuser,   // op
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // granted, granted_index,
                                               // op_utilization, used_now,
                                               // utilization_now, peak_percent,
                                               // hit_total, miss_total,
                                               // request_total, high_use, zeros
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_DATA_W-1:0]  csr_wdata    // warn_threshold
);

   localparam int unsigned SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int unsigned USED_W = $clog2(POOL_SLOTS + 1);

   typedef logic [PCT_W-1:0] pct_arr_type [POOL_SLOTS+1];

   function automatic pct_arr_type build_pct();
      pct_arr_type t;
      for (int i = 0; i <= int'(POOL_SLOTS); i++) begin
         t[i] = PCT_W'((i * 100) / POOL_SLOTS);
      end
      return t;
   endfunction

   localparam pct_arr_type PCT_TABLE = build_pct();

   logic                   s1_valid_ff;
   op_type                 s1_op_ff;
   logic [SLOT_IDX_W-1:0]  s1_slot_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;
   rsp_type                rsp_data_in;

   logic [POOL_SLOTS-1:0]  free_ff, free_in;
   logic [USED_W-1:0]      used_ff, used_in;
   logic [COUNT_W-1:0]     hit_ff, hit_in;
   logic [COUNT_W-1:0]     miss_ff, miss_in;
   logic [PCT_W-1:0]       peak_ff, peak_in;
   logic [PCT_W-1:0]       thr_ff;

   logic                   s1_fire;
   logic                   req_fire;
   logic [POOL_SLOTS-1:0]  lowest_free;
   logic [SLOT_W-1:0]      lowest_idx;
   logic                   any_free;
   logic                   in_pool;
   logic [SLOT_W-1:0]      slot_sel;
   logic                   was_used;
   logic [PCT_W-1:0]       op_util;
   logic                   miss;
   logic                   granted;
   logic [SLOT_IDX_W-1:0]  gidx;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_data_ff};

   // lowest free slot
   assign lowest_free = free_ff & (~free_ff + POOL_SLOTS'(1));
   assign any_free    = |free_ff;

   always_comb begin
      lowest_idx = '0;
      for (int i = 0; i < int'(POOL_SLOTS); i++) begin
         lowest_idx = lowest_idx | (lowest_free[i] ? SLOT_W'(i) : '0);
      end
   end

   assign in_pool  = {1'b0, s1_slot_ff} < USED_OUT_W'(POOL_SLOTS);
   assign slot_sel = s1_slot_ff[SLOT_W-1:0];
   assign was_used = in_pool && !free_ff[slot_sel];

   always_comb begin
      free_in = free_ff;
      used_in = used_ff;
      hit_in  = hit_ff;
      miss_in = miss_ff;
      peak_in = peak_ff;
      op_util = '0;
      miss    = 1'b0;
      granted = 1'b0;
      gidx    = '0;
      unique case (s1_op_ff)
         OP_GET: begin
            op_util = PCT_TABLE[used_ff];
            if (op_util > peak_ff) begin
               peak_in = op_util;
            end
            if (any_free) begin
               free_in = free_ff & ~lowest_free;
               used_in = used_ff + USED_W'(1);
               hit_in  = hit_ff + COUNT_W'(1);
               granted = 1'b1;
               gidx    = SLOT_IDX_W'(lowest_idx);
            end else begin
               miss    = 1'b1;
               miss_in = miss_ff + COUNT_W'(1);
            end
         end
         OP_RETURN: begin
            if (in_pool) begin
               free_in[slot_sel] = 1'b1;
               granted           = 1'b1;
               gidx              = s1_slot_ff;
            end
            used_in = used_ff - USED_W'(was_used);
            op_util = PCT_TABLE[used_in];
         end
         default: begin
         end
      endcase

      rsp_data_in.granted         = granted;
      rsp_data_in.granted_index   = gidx;
      rsp_data_in.op_utilization  = op_util;
      rsp_data_in.used_now        = USED_OUT_W'(used_in);
      rsp_data_in.utilization_now = PCT_TABLE[used_in];
      rsp_data_in.peak_percent    = peak_in;
      rsp_data_in.hit_total       = hit_in;
      rsp_data_in.miss_total      = miss_in;
      rsp_data_in.request_total   = TOTAL_W'(hit_in) + TOTAL_W'(miss_in);
      rsp_data_in.high_use        = miss || (op_util > thr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         free_ff      <= '1;
         used_ff      <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         peak_ff      <= '0;
         thr_ff       <= WARN_THRESHOLD_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_wdata;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
            free_ff      <= free_in;
            used_ff      <= used_in;
            hit_ff       <= hit_in;
            miss_ff      <= miss_in;
            peak_ff      <= peak_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= op_type'(req_tuser);
         s1_slot_ff <= req_tdata;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // used count tracks the free map
   assert property (@(posedge clock) disable iff (reset)
      32'(used_ff) == 32'(POOL_SLOTS) - 32'($countones(free_ff)))
      else $error("used count out of step with free map");

   // a miss only when the pool is full
   assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_op_ff == OP_GET && !any_free |-> 32'(used_ff) == 32'(POOL_SLOTS))
      else $error("miss with slots still free");

   // a granted get takes exactly one slot
   assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_op_ff == OP_GET && any_free |=> used_ff == $past(used_ff) + USED_W'(1))
      else $error("granted get did not take one slot");

   // peak never falls
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> peak_ff >= $past(peak_ff))
      else $error("peak utilization decreased");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the buffer pool slot allocator with a shadow free map and stats
module tb_top
   import bpsa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned POOL        = 32;
   localparam int unsigned HOLD_CYCLES = 64;
   localparam int unsigned BLOCK_ITEMS = 40;
   localparam int unsigned BLOCKS      = 8;

   class slot_scoreboard;
      bit [POOL-1:0] slot_free;
      bit [31:0]     hits;
      bit [31:0]     misses;
      int unsigned   peak_pct;
      int unsigned   threshold;
      int unsigned   failures;
      rsp_type       grants_due[$];

      function new();
         slot_free = '1;
         hits      = '0;
         misses    = '0;
         peak_pct  = 0;
         threshold = WARN_THRESHOLD_RESET;
         failures  = 0;
      endfunction

      function int unsigned pct_of(int unsigned n);
         return n * 100 / POOL;
      endfunction

      function void set_threshold(bit [CSR_DATA_W-1:0] pct);
         threshold = pct;
      endfunction

      function void take_request(op_type op, bit [SLOT_IDX_W-1:0] idx);
         rsp_type     r;
         int unsigned pct;
         int unsigned lowest;
         bit          missed;
         r      = '0;
         missed = 1'b0;
         if (op == OP_GET) begin
            pct = pct_of(POOL - $countones(slot_free));
            if (pct > peak_pct) peak_pct = pct;
            if (slot_free == '0) begin
               missed = 1'b1;
               misses++;
            end else begin
               lowest = 0;
               for (int i = POOL; i > 0; i--) begin
                  if (slot_free[i-1]) lowest = i - 1;
               end
               slot_free[lowest] = 1'b0;
               r.granted         = 1'b1;
               r.granted_index   = lowest;
               hits++;
            end
         end else begin
            if (idx < POOL) begin
               slot_free[idx]  = 1'b1;
               r.granted       = 1'b1;
               r.granted_index = idx;
            end
            pct = pct_of(POOL - $countones(slot_free));
         end
         r.op_utilization  = pct;
         r.used_now        = POOL - $countones(slot_free);
         r.utilization_now = pct_of(POOL - $countones(slot_free));
         r.peak_percent    = peak_pct;
         r.hit_total       = hits;
         r.miss_total      = misses;
         r.request_total   = {1'b0, hits} + {1'b0, misses};
         r.high_use        = missed || (pct > threshold);
         grants_due.push_back(r);
      endfunction

      function void compare(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_grant(logic [RSP_TDATA_W-1:0] data);
         rsp_type got;
         rsp_type want;
         got = data[$bits(rsp_type)-1:0];
         if (grants_due.size() == 0) begin
            $error("result item with no request outstanding");
            failures++;
            return;
         end
         want = grants_due.pop_front();
         compare("granted", want.granted, got.granted);
         compare("granted_index", want.granted_index, got.granted_index);
         compare("op_utilization", want.op_utilization, got.op_utilization);
         compare("used_now", want.used_now, got.used_now);
         compare("utilization_now", want.utilization_now, got.utilization_now);
         compare("peak_percent", want.peak_percent, got.peak_percent);
         compare("hit_total", want.hit_total, got.hit_total);
         compare("miss_total", want.miss_total, got.miss_total);
         compare("request_total", want.request_total, got.request_total);
         compare("high_use", want.high_use, got.high_use);
         compare("padding", 64'd0, data >> $bits(rsp_type));
      endfunction
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;    // slot_index
   logic                   req_tuser  = OP_GET; // op
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;          // granted, granted_index, op_utilization,
                                               // used_now, utilization_now, peak_percent,
                                               // hit_total, miss_total, request_total,
                                               // high_use, zeros
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;    // warn_threshold

   slot_scoreboard pool_sb;
   bit             no_gaps       = 1'b0;
   bit             hold_off_req  = 1'b0;

   buffer_pool_slot_allocator_top #(
      .POOL_SLOTS(POOL)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Mismatches found");
      $finish;
   end

   task automatic send_request(op_type op, logic [SLOT_IDX_W-1:0] idx);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= idx;
      do @(posedge clock); while (!req_tready);
      pool_sb.take_request(op, idx);
   endtask

   task automatic write_threshold(logic [CSR_DATA_W-1:0] pct);
      csr_valid <= 1'b1;
      csr_wdata <= pct;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pool_sb.set_threshold(pct);
   endtask

   task automatic wait_drained(int unsigned settle);
      while (pool_sb.grants_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // result side: random stalls plus the occasional long hold-off
   initial begin
      int unsigned gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = no_gaps ? 0 : $urandom_range(0, 7);
         if (hold_off_req) begin
            gap          = gap + HOLD_CYCLES;
            hold_off_req = 1'b0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         pool_sb.check_grant(rsp_tdata);
      end
   end

   initial begin
      int unsigned      thresholds[6];
      int unsigned      biases[5];
      int unsigned      bias;
      op_type           op;
      logic [SLOT_IDX_W-1:0] idx;

      pool_sb    = new();
      thresholds = '{0, 127, 100, 101, 0, 80};
      thresholds[4] = $urandom_range(1, 99);
      biases     = '{5, 30, 60, 85, 100};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items at the reset threshold
      send_request(OP_GET, 8'd255);
      send_request(OP_GET, 8'd0);
      send_request(OP_GET, 8'd0);
      send_request(OP_RETURN, 8'd1);
      send_request(OP_GET, 8'd0);
      send_request(OP_RETURN, 8'd0);
      send_request(OP_RETURN, 8'd0);
      send_request(OP_RETURN, POOL - 1);
      send_request(OP_RETURN, POOL);
      send_request(OP_RETURN, 8'd255);
      send_request(OP_GET, 8'd128);
      send_request(OP_RETURN, 8'd2);
      send_request(OP_RETURN, 8'd1);

      for (int ph = 0; ph < 6; ph++) begin
         req_tvalid <= 1'b0;
         wait_drained(4);
         write_threshold(thresholds[ph]);
         for (int blk = 0; blk < BLOCKS; blk++) begin
            bias    = biases[$urandom_range(0, 4)];
            no_gaps = ($urandom_range(0, 3) == 0);
            // receiver stalls long enough for the input side to back up
            if ((ph == 2 || ph == 4) && blk == 3) begin
               no_gaps      = 1'b1;
               hold_off_req = 1'b1;
            end
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
               op = ($urandom_range(0, 99) < bias) ? OP_GET : OP_RETURN;
               if (op == OP_GET || $urandom_range(0, 9) == 0)
                  idx = $urandom_range(0, 255);
               else
                  idx = $urandom_range(0, POOL - 1);
               send_request(op, idx);
            end
         end
         no_gaps = 1'b0;
      end

      req_tvalid <= 1'b0;
      wait_drained(10);
      if (pool_sb.failures == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
